FILE: rtl/core/cpt_pkg.sv
// Shared types, codes and punctuator lookup functions for the C preprocessing tokenizer.
package cpt_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int FIFO_DEPTH    = 8;
    localparam int MAX_RES       = 3;

    localparam logic [2:0] K_PUNCT   = 3'd0;
    localparam logic [2:0] K_SPACE   = 3'd1;
    localparam logic [2:0] K_NEWLINE = 3'd2;
    localparam logic [2:0] K_IDENT   = 3'd3;
    localparam logic [2:0] K_NUMBER  = 3'd4;
    localparam logic [2:0] K_CHAR    = 3'd5;
    localparam logic [2:0] K_STRING  = 3'd6;
    localparam logic [2:0] K_UNKNOWN = 3'd7;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_BCOMMENT = 2'd1;
    localparam logic [1:0] E_NLQUOTE  = 2'd2;

    localparam logic [5:0] DOT_CODE  = 6'd42;
    localparam logic [5:0] NO_CODE   = 6'd63;

    localparam logic [0:0] REG_SOURCE_ID = 1'b0;

    typedef enum logic [3:0] {
        M_IDLE, M_PUNCT, M_DOT, M_IDENT, M_NUMBER,
        M_LCOMMENT, M_BCOMMENT, M_CHARQ, M_STRQ
    } t_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  code;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] len;
        logic [1:0]  err;
        logic        last;
    } t_tok;

    // Single-byte punctuator code, NO_CODE if none (dot handled apart)
    function automatic logic [5:0] punct1(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "|": k = 6'd2;   "^": k = 6'd4;   "&": k = 6'd7;   "<": k = 6'd11;
            ">": k = 6'd15;  "+": k = 6'd18;  "-": k = 6'd21;  "*": k = 6'd23;
            "/": k = 6'd25;  "%": k = 6'd27;  "(": k = 6'd28;  ")": k = 6'd29;
            "{": k = 6'd30;  "}": k = 6'd31;  "[": k = 6'd32;  "]": k = 6'd33;
            ";": k = 6'd34;  ":": k = 6'd35;  ",": k = 6'd36;  "~": k = 6'd37;
            "!": k = 6'd39;  "?": k = 6'd40;  "#": k = 6'd41;  "=": k = 6'd45;
            default: k = NO_CODE;
        endcase
        return k;
    endfunction

    // Byte that can open a longer punctuator
    function automatic logic ext1(input logic [7:0] c);
        logic r;
        case (c)
            "|", "^", "&", "<", ">", "+", "-", "*", "/", "%", "!", "=": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Two-byte punctuator code, NO_CODE if none
    function automatic logic [5:0] punct2(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        case ({a, b})
            "||": k = 6'd0;   "|=": k = 6'd1;   "^=": k = 6'd3;   "&&": k = 6'd5;
            "&=": k = 6'd6;   "<<": k = 6'd9;   "<=": k = 6'd10;  ">>": k = 6'd13;
            ">=": k = 6'd14;  "+=": k = 6'd16;  "++": k = 6'd17;  "-=": k = 6'd19;
            "--": k = 6'd20;  "*=": k = 6'd22;  "/=": k = 6'd24;  "%=": k = 6'd26;
            "!=": k = 6'd38;  "->": k = 6'd43;  "==": k = 6'd44;
            default: k = NO_CODE;
        endcase
        return k;
    endfunction

    // Two-byte prefix of a three-byte punctuator
    function automatic logic ext2(input logic [7:0] a, input logic [7:0] b);
        return ({a, b} == "<<") || ({a, b} == ">>");
    endfunction

    // Three-byte punctuator code, NO_CODE if none
    function automatic logic [5:0] punct3(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        logic [5:0] k;
        case ({a, b, c})
            "<<=":   k = 6'd8;
            ">>=":   k = 6'd12;
            default: k = NO_CODE;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

endpackage

FILE: rtl/core/c_preprocessing_tokenizer.sv
// Top level of the C preprocessing tokenizer: input register, lexer, result queue, APB port.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_ch, i_end_of_input
//  output   | o_out_valid  | i_out_stall  | o_token_kind ... o_last_of_run (one per token)
//  config   | psel/penable | pready = 1   | paddr, pwdata, prdata (source_id at 0)
//
// One byte per cycle while o_in_stall is low: a byte is held in the input register, then
// the lexer step turns it into zero to three tokens, queued in an eight-entry result queue.
// The queue pops one token per cycle when i_out_stall is low; the input stalls while fewer
// than three free entries remain. Synchronous reset clears the lexer to row 1, column 1.
module c_preprocessing_tokenizer #(
    parameter int POS_WIDTH = cpt_pkg::POS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_kind,
    output logic [5:0]  o_punct_code,
    output logic [15:0] o_start_row,
    output logic [15:0] o_start_col,
    output logic [15:0] o_token_length,
    output logic [15:0] o_file_id,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           r_in_valid;
    logic [7:0]     r_ch;
    logic           r_eoi;
    logic [15:0]    r_source_id;
    logic           room, step, pop;
    cpt_pkg::t_tok  slot [cpt_pkg::MAX_RES];
    logic [1:0]     cnt;
    cpt_pkg::t_tok  head;

    assign step       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign pop        = o_out_valid && !i_out_stall;

    // Hold the accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_ch  <= i_ch;
            r_eoi <= i_end_of_input;
        end
    end

    // Write the source identifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id <= 16'd0;
        end else if (psel && penable && pwrite && pready && paddr[2] == cpt_pkg::REG_SOURCE_ID
                     && paddr[1:0] == 2'd0) begin
            r_source_id <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cpt_pkg::REG_SOURCE_ID) ? {16'd0, r_source_id} : 32'd0;

    cpt_lexer #(.POS_WIDTH(POS_WIDTH)) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_ch),
        .i_eoi   (r_eoi),
        .o_slot  (slot),
        .o_count (cnt)
    );

    cpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (slot),
        .i_count (step ? cnt : 2'd0),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (o_out_valid),
        .o_room  (room)
    );

    assign o_token_kind   = head.kind;
    assign o_punct_code   = head.code;
    assign o_start_row    = head.row;
    assign o_start_col    = head.col;
    assign o_token_length = head.len;
    assign o_file_id      = r_source_id;
    assign o_error_code   = head.err;
    assign o_last_of_run  = head.last;

endmodule

FILE: rtl/core/cpt_lexer.sv
// Lexer state registers and the per-byte step that yields up to three token slots.
module cpt_lexer #(
    parameter int POS_WIDTH = cpt_pkg::POS_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_ch,
    input  logic             i_eoi,
    output cpt_pkg::t_tok    o_slot [cpt_pkg::MAX_RES],
    output logic [1:0]       o_count
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

    cpt_pkg::t_mode         r_mode, n_mode;
    logic [7:0]             r_pb0, n_pb0, r_pb1, n_pb1;
    logic [1:0]             r_pc, n_pc;
    logic [7:0]             r_prev, n_prev;
    logic [POS_WIDTH-1:0]   r_tsr, n_tsr, r_tsc, n_tsc, r_row, n_row, r_col, n_col;
    logic [15:0]            r_olen, n_olen;
    logic                   r_fail, n_fail;

    cpt_pkg::t_tok          slot [cpt_pkg::MAX_RES];
    logic [1:0]             ne;

    // Next state and emitted slots for one byte
    always_comb begin
        logic       disp;
        logic [5:0] k;
        logic [7:0] q;
        logic [2:0] qk;
        n_mode = r_mode; n_pb0 = r_pb0; n_pb1 = r_pb1; n_pc = r_pc; n_prev = r_prev;
        n_tsr = r_tsr; n_tsc = r_tsc; n_row = r_row; n_col = r_col;
        n_olen = r_olen; n_fail = r_fail;
        ne = 2'd0;
        disp = 1'b0;
        k = cpt_pkg::NO_CODE;
        q = 8'd0;
        qk = cpt_pkg::K_CHAR;
        for (int i = 0; i < cpt_pkg::MAX_RES; i++) begin
            slot[i] = '0;
        end
        if (r_fail) begin
            if (i_eoi) begin
                n_fail = 1'b0;
            end
        end else begin
            // Continue the open token
            case (r_mode)
                cpt_pkg::M_PUNCT: begin
                    if (r_pc == 2'd1) begin
                        if (r_pb0 == "/" && (i_ch == "/" || i_ch == "*")) begin
                            n_mode = (i_ch == "/") ? cpt_pkg::M_LCOMMENT : cpt_pkg::M_BCOMMENT;
                            n_olen = 16'd2;
                            n_prev = 8'd0;
                            n_pc = 2'd0;
                        end else if (cpt_pkg::ext2(r_pb0, i_ch)) begin
                            n_pb1 = i_ch;
                            n_pc = 2'd2;
                            n_olen = 16'd2;
                        end else begin
                            k = cpt_pkg::punct2(r_pb0, i_ch);
                            if (k != cpt_pkg::NO_CODE) begin
                                slot[ne] = '{cpt_pkg::K_PUNCT, k, 16'(r_tsr), 16'(r_tsc),
                                             16'd2, cpt_pkg::E_NONE, 1'b0};
                            end else begin
                                k = cpt_pkg::punct1(r_pb0);
                                slot[ne] = '{cpt_pkg::K_PUNCT,
                                             (k == cpt_pkg::NO_CODE) ? 6'd0 : k,
                                             16'(r_tsr), 16'(r_tsc), 16'd1,
                                             cpt_pkg::E_NONE, 1'b0};
                                disp = 1'b1;
                            end
                            ne = ne + 2'd1;
                            n_mode = cpt_pkg::M_IDLE;
                            n_pc = 2'd0;
                        end
                    end else if (r_pc == 2'd2) begin
                        k = cpt_pkg::punct3(r_pb0, r_pb1, i_ch);
                        if (k != cpt_pkg::NO_CODE) begin
                            slot[ne] = '{cpt_pkg::K_PUNCT, k, 16'(r_tsr), 16'(r_tsc),
                                         16'd3, cpt_pkg::E_NONE, 1'b0};
                        end else begin
                            k = cpt_pkg::punct2(r_pb0, r_pb1);
                            slot[ne] = '{cpt_pkg::K_PUNCT,
                                         (k == cpt_pkg::NO_CODE) ? 6'd0 : k,
                                         16'(r_tsr), 16'(r_tsc), 16'd2,
                                         cpt_pkg::E_NONE, 1'b0};
                            disp = 1'b1;
                        end
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                    end else begin
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                        disp = 1'b1;
                    end
                end
                cpt_pkg::M_DOT: begin
                    if (cpt_pkg::is_digit(i_ch)) begin
                        n_mode = cpt_pkg::M_NUMBER;
                        n_olen = 16'd2;
                        n_prev = i_ch;
                    end else begin
                        slot[ne] = '{cpt_pkg::K_PUNCT, cpt_pkg::DOT_CODE, 16'(r_tsr),
                                     16'(r_tsc), r_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                        disp = 1'b1;
                    end
                end
                cpt_pkg::M_IDENT: begin
                    if (cpt_pkg::is_alpha(i_ch) || cpt_pkg::is_digit(i_ch) || i_ch == "_") begin
                        n_olen = (r_olen != 16'hFFFF) ? r_olen + 16'd1 : r_olen;
                    end else begin
                        slot[ne] = '{cpt_pkg::K_IDENT, 6'd0, 16'(r_tsr), 16'(r_tsc),
                                     r_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                        disp = 1'b1;
                    end
                end
                cpt_pkg::M_NUMBER: begin
                    if (cpt_pkg::is_alpha(i_ch) || cpt_pkg::is_digit(i_ch) || i_ch == "." ||
                        ((i_ch == "+" || i_ch == "-") &&
                         (r_prev == "e" || r_prev == "E" || r_prev == "p" || r_prev == "P")))
                    begin
                        n_olen = (r_olen != 16'hFFFF) ? r_olen + 16'd1 : r_olen;
                        n_prev = i_ch;
                    end else begin
                        slot[ne] = '{cpt_pkg::K_NUMBER, 6'd0, 16'(r_tsr), 16'(r_tsc),
                                     r_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                        disp = 1'b1;
                    end
                end
                cpt_pkg::M_LCOMMENT: begin
                    if (i_ch == "\n") begin
                        slot[ne] = '{cpt_pkg::K_SPACE, 6'd0, 16'(r_tsr), 16'(r_tsc),
                                     r_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                        disp = 1'b1;
                    end else begin
                        n_olen = (r_olen != 16'hFFFF) ? r_olen + 16'd1 : r_olen;
                    end
                end
                cpt_pkg::M_BCOMMENT: begin
                    n_olen = (r_olen != 16'hFFFF) ? r_olen + 16'd1 : r_olen;
                    if (r_prev == "*" && i_ch == "/") begin
                        slot[ne] = '{cpt_pkg::K_SPACE, 6'd0, 16'(r_tsr), 16'(r_tsc),
                                     n_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                    end else begin
                        n_prev = i_ch;
                    end
                end
                cpt_pkg::M_CHARQ, cpt_pkg::M_STRQ: begin
                    q  = (r_mode == cpt_pkg::M_CHARQ) ? 8'h27 : 8'h22;
                    qk = (r_mode == cpt_pkg::M_CHARQ) ? cpt_pkg::K_CHAR : cpt_pkg::K_STRING;
                    if (i_ch == "\n") begin
                        slot[ne] = '{qk, 6'd0, 16'(r_tsr), 16'(r_tsc), r_olen,
                                     cpt_pkg::E_NLQUOTE, 1'b0};
                        ne = ne + 2'd1;
                        n_mode = cpt_pkg::M_IDLE;
                        n_pc = 2'd0;
                        n_fail = 1'b1;
                    end else begin
                        n_olen = (r_olen != 16'hFFFF) ? r_olen + 16'd1 : r_olen;
                        if (i_ch == q) begin
                            slot[ne] = '{qk, 6'd0, 16'(r_tsr), 16'(r_tsc), n_olen,
                                         cpt_pkg::E_NONE, 1'b0};
                            ne = ne + 2'd1;
                            n_mode = cpt_pkg::M_IDLE;
                            n_pc = 2'd0;
                        end
                    end
                end
                default: begin
                    n_mode = cpt_pkg::M_IDLE;
                    disp = 1'b1;
                end
            endcase

            // Start a new token from this byte
            if (disp) begin
                k = cpt_pkg::punct1(i_ch);
                if (i_ch == ".") begin
                    n_mode = cpt_pkg::M_DOT; n_olen = 16'd1; n_tsr = r_row; n_tsc = r_col;
                end else if (cpt_pkg::ext1(i_ch)) begin
                    n_mode = cpt_pkg::M_PUNCT; n_olen = 16'd1; n_tsr = r_row; n_tsc = r_col;
                    n_pb0 = i_ch;
                    n_pc = 2'd1;
                end else if (k != cpt_pkg::NO_CODE) begin
                    slot[ne] = '{cpt_pkg::K_PUNCT, k, 16'(r_row), 16'(r_col), 16'd1,
                                 cpt_pkg::E_NONE, 1'b0};
                    ne = ne + 2'd1;
                end else if (i_ch == " ") begin
                    slot[ne] = '{cpt_pkg::K_SPACE, 6'd0, 16'(r_row), 16'(r_col), 16'd1,
                                 cpt_pkg::E_NONE, 1'b0};
                    ne = ne + 2'd1;
                end else if (i_ch == "\n") begin
                    slot[ne] = '{cpt_pkg::K_NEWLINE, 6'd0, 16'(r_row), 16'(r_col), 16'd1,
                                 cpt_pkg::E_NONE, 1'b0};
                    ne = ne + 2'd1;
                end else if (cpt_pkg::is_alpha(i_ch) || i_ch == "_") begin
                    n_mode = cpt_pkg::M_IDENT; n_olen = 16'd1; n_tsr = r_row; n_tsc = r_col;
                end else if (cpt_pkg::is_digit(i_ch)) begin
                    n_mode = cpt_pkg::M_NUMBER; n_olen = 16'd1; n_tsr = r_row; n_tsc = r_col;
                    n_prev = i_ch;
                end else if (i_ch == 8'h27) begin
                    n_mode = cpt_pkg::M_CHARQ; n_olen = 16'd1; n_tsr = r_row; n_tsc = r_col;
                end else if (i_ch == 8'h22) begin
                    n_mode = cpt_pkg::M_STRQ; n_olen = 16'd1; n_tsr = r_row; n_tsc = r_col;
                end else begin
                    slot[ne] = '{cpt_pkg::K_UNKNOWN, 6'd0, 16'(r_row), 16'(r_col), 16'd1,
                                 cpt_pkg::E_NONE, 1'b0};
                    ne = ne + 2'd1;
                end
            end

            // Advance the position
            if (i_ch == "\n") begin
                n_row = (r_row != POS_MAX) ? r_row + POS_ONE : r_row;
                n_col = POS_ONE;
            end else begin
                n_col = (r_col != POS_MAX) ? r_col + POS_ONE : r_col;
            end

            // Flush the open token at end of file
            if (i_eoi && !n_fail) begin
                case (n_mode)
                    cpt_pkg::M_PUNCT: begin
                        if (n_pc == 2'd1) begin
                            k = cpt_pkg::punct1(n_pb0);
                        end else if (n_pc == 2'd2) begin
                            k = cpt_pkg::punct2(n_pb0, n_pb1);
                        end else begin
                            k = cpt_pkg::NO_CODE;
                        end
                        slot[ne] = '{cpt_pkg::K_PUNCT, (k == cpt_pkg::NO_CODE) ? 6'd0 : k,
                                     16'(n_tsr), 16'(n_tsc), n_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                    end
                    cpt_pkg::M_DOT: begin
                        slot[ne] = '{cpt_pkg::K_PUNCT, cpt_pkg::DOT_CODE, 16'(n_tsr),
                                     16'(n_tsc), n_olen, cpt_pkg::E_NONE, 1'b0};
                        ne = ne + 2'd1;
                    end
                    cpt_pkg::M_IDENT, cpt_pkg::M_NUMBER, cpt_pkg::M_LCOMMENT,
                    cpt_pkg::M_BCOMMENT, cpt_pkg::M_CHARQ, cpt_pkg::M_STRQ: begin
                        case (n_mode)
                            cpt_pkg::M_IDENT:    qk = cpt_pkg::K_IDENT;
                            cpt_pkg::M_NUMBER:   qk = cpt_pkg::K_NUMBER;
                            cpt_pkg::M_CHARQ:    qk = cpt_pkg::K_CHAR;
                            cpt_pkg::M_STRQ:     qk = cpt_pkg::K_STRING;
                            default:             qk = cpt_pkg::K_SPACE;
                        endcase
                        slot[ne] = '{qk, 6'd0, 16'(n_tsr), 16'(n_tsc), n_olen,
                                     (n_mode == cpt_pkg::M_BCOMMENT) ? cpt_pkg::E_BCOMMENT
                                                                     : cpt_pkg::E_NONE,
                                     1'b0};
                        ne = ne + 2'd1;
                    end
                    default: ;
                endcase
            end
        end

        // Return to a fresh file after the last byte
        if (i_eoi) begin
            n_mode = cpt_pkg::M_IDLE; n_pb0 = 8'd0; n_pb1 = 8'd0; n_pc = 2'd0;
            n_prev = 8'd0; n_tsr = POS_ONE; n_tsc = POS_ONE; n_row = POS_ONE;
            n_col = POS_ONE; n_olen = 16'd0; n_fail = 1'b0;
        end
    end

    // Mark the last slot of the byte
    always_comb begin
        for (int i = 0; i < cpt_pkg::MAX_RES; i++) begin
            o_slot[i] = slot[i];
            o_slot[i].last = (2'(i) == ne - 2'd1);
        end
        o_count = ne;
    end

    // Hold state until a byte is stepped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cpt_pkg::M_IDLE; r_pb0 <= 8'd0; r_pb1 <= 8'd0; r_pc <= 2'd0;
            r_prev <= 8'd0; r_tsr <= POS_ONE; r_tsc <= POS_ONE; r_row <= POS_ONE;
            r_col <= POS_ONE; r_olen <= 16'd0; r_fail <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode; r_pb0 <= n_pb0; r_pb1 <= n_pb1; r_pc <= n_pc;
            r_prev <= n_prev; r_tsr <= n_tsr; r_tsc <= n_tsc; r_row <= n_row;
            r_col <= n_col; r_olen <= n_olen; r_fail <= n_fail;
        end
    end

endmodule

FILE: rtl/core/cpt_fifo.sv
// Result queue that takes up to three token slots per cycle and delivers one.
module cpt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpt_pkg::t_tok  i_slot [cpt_pkg::MAX_RES],
    input  logic [1:0]     i_count,
    input  logic           i_pop,
    output cpt_pkg::t_tok  o_head,
    output logic           o_valid,
    output logic           o_room
);

    localparam int AW = $clog2(cpt_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(cpt_pkg::FIFO_DEPTH + 1);

    cpt_pkg::t_tok   r_mem [cpt_pkg::FIFO_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign o_room  = (r_cnt <= CW'(cpt_pkg::FIFO_DEPTH - cpt_pkg::MAX_RES));

    // Write the new slots
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < cpt_pkg::MAX_RES; i++) begin
            if (2'(i) < i_count) begin
                r_mem[AW'(r_wp + AW'(i))] <= i_slot[i];
            end
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= r_wp + AW'(i_count);
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_count) - CW'(i_pop);
        end
    end

endmodule
